@@ rtl/bhd_pkg.sv @@
// ----------------------------------------------------------------------------
// bhd_pkg
// Shared constants and types for the button history debouncer: register
// indexes, reset values, machine phases and match groups.
// ----------------------------------------------------------------------------
package bhd_pkg;

	// history depth; masks and patterns always cover the low 16 bits
	localparam int HISTORY_BITS = 16;
	localparam int MATCH_W      = 16;
	localparam int TICK_W       = 32;
	localparam int CFG_W        = 16;
	localparam int CFG_IDX_W    = 3;
	localparam int FEAT_W       = 2;

	// register reset values
	localparam logic              RST_ACTIVE_LOW      = 1'b1;
	localparam logic [FEAT_W-1:0] RST_FEATURE_ENABLE  = '0;
	localparam logic [CFG_W-1:0]  RST_DOUBLE_WINDOW   = 16'd300;
	localparam logic [CFG_W-1:0]  RST_LONG_THRESHOLD  = 16'd1000;
	localparam logic [CFG_W-1:0]  RST_PRESS_MASK      = 16'd61503;
	localparam logic [CFG_W-1:0]  RST_PRESS_PATTERN   = 16'd63;
	localparam logic [CFG_W-1:0]  RST_RELEASE_MASK    = 16'd64527;
	localparam logic [CFG_W-1:0]  RST_RELEASE_PATTERN = 16'd64512;

	// feature enable bits
	localparam int FEAT_DOUBLE = 0;
	localparam int FEAT_LONG   = 1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ACTIVE_LOW      = 3'd0,
		REG_FEATURE_ENABLE  = 3'd1,
		REG_DOUBLE_WINDOW   = 3'd2,
		REG_LONG_THRESHOLD  = 3'd3,
		REG_PRESS_MASK      = 3'd4,
		REG_PRESS_PATTERN   = 3'd5,
		REG_RELEASE_MASK    = 3'd6,
		REG_RELEASE_PATTERN = 3'd7
	} cfg_reg_t;

	typedef enum logic [3:0] {
		PH_IDLE    = 4'b0001,
		PH_PRESS   = 4'b0010,
		PH_RELEASE = 4'b0100,
		PH_LONG    = 4'b1000
	} phase_t;

	// press and release match settings
	typedef struct packed {
		logic [MATCH_W-1:0] press_mask;
		logic [MATCH_W-1:0] press_pattern;
		logic [MATCH_W-1:0] release_mask;
		logic [MATCH_W-1:0] release_pattern;
	} pat_cfg_t;

	// match and status flags for one history value
	typedef struct packed {
		logic press_match;
		logic release_match;
		logic held;
		logic idle;
	} match_t;

endpackage

@@ rtl/bhd_match.sv @@
// ----------------------------------------------------------------------------
// bhd_match
// Masked press and release matches on the history, plus all-pressed and
// all-released status.
// ----------------------------------------------------------------------------
module bhd_match (
	input  logic [bhd_pkg::HISTORY_BITS-1:0] hist,
	input  bhd_pkg::pat_cfg_t                pat,
	output bhd_pkg::match_t                  flags
);
	import bhd_pkg::*;

	logic [MATCH_W+HISTORY_BITS-1:0] hist_ext;
	logic [MATCH_W-1:0]              view;

	// low 16 bits of the history, missing bits read as released
	assign hist_ext = {{MATCH_W{1'b0}}, hist};
	assign view     = hist_ext[MATCH_W-1:0];

	// pattern compares and steady status
	assign flags.press_match   = (view & pat.press_mask) == pat.press_pattern;
	assign flags.release_match = (view & pat.release_mask) == pat.release_pattern;
	assign flags.held          = &hist;
	assign flags.idle          = ~|hist;

endmodule

@@ rtl/button_history_debouncer_core.sv @@
// ----------------------------------------------------------------------------
// button_history_debouncer_core
// Shift-register debouncer with masked press/release matching and a
// single / double / long press detector timed by a count of accepted sample ticks.
// ----------------------------------------------------------------------------
// One request is one sample tick and yields one result. The block takes a
// request every clock cycle while the result side does not stall. A result
// passes through the input register stage and then the result register before
// it shows on the outputs, and is taken at an edge where out_ready is high.
// The input stage keeps accepting while a result waits to be taken, until
// both stages are full. Configuration writes apply at once and are meant
// to happen only while no request is in flight.
module button_history_debouncer_core (
	input  logic                         clk,
	input  logic                         arst_n,
	// sample channel
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         raw_level,
	// result channel
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         press_pulse,
	output logic                         release_pulse,
	output logic                         held_steady,
	output logic                         idle_steady,
	output logic                         single_pulse,
	output logic                         double_pulse,
	output logic                         long_start_pulse,
	output logic                         long_end_pulse,
	output logic                         long_active,
	output logic                         click_count,
	// configuration writes
	input  logic                         cfg_we,
	input  logic [bhd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bhd_pkg::CFG_W-1:0]    cfg_data
);
	import bhd_pkg::*;

	typedef struct packed {
		logic press_pulse;
		logic release_pulse;
		logic held_steady;
		logic idle_steady;
		logic single_pulse;
		logic double_pulse;
		logic long_start_pulse;
		logic long_end_pulse;
		logic long_active;
		logic click_count;
	} res_t;

	// configuration registers
	logic              active_low_q;
	logic [FEAT_W-1:0] feat_q;
	logic [CFG_W-1:0]  dwin_q;
	logic [CFG_W-1:0]  lthr_q;
	pat_cfg_t          pat_q;

	// detector state
	logic [HISTORY_BITS-1:0] hist_q;
	phase_t                  phase_q;
	logic [TICK_W-1:0]       tick_q;
	logic [TICK_W-1:0]       pstamp_q;
	logic [TICK_W-1:0]       rstamp_q;
	logic                    long_q;
	logic                    clicks_q;
	logic                    pseen_q;
	logic                    rseen_q;

	// pipeline
	logic  valid_s1;
	logic  raw_s1;
	logic  out_valid_q;
	res_t  res_q;

	// next-state values
	logic                    adv;
	logic                    pressed;
	logic [HISTORY_BITS-1:0] hist_d;
	logic [TICK_W-1:0]       tick_d;
	logic [TICK_W-1:0]       el_press;
	logic [TICK_W-1:0]       el_release;
	logic                    long_due;
	logic                    in_window;
	match_t                  flags;
	phase_t                  phase_d;
	logic [TICK_W-1:0]       pstamp_d;
	logic [TICK_W-1:0]       rstamp_d;
	logic                    long_d;
	logic                    clicks_d;
	res_t                    res_d;
	cfg_reg_t                cfg_sel;

	// handshake
	assign adv      = valid_s1 & (~out_valid_q | out_ready);
	assign in_ready = ~valid_s1 | adv;
	assign cfg_sel  = cfg_reg_t'(cfg_index);

	// new sample into the history
	assign pressed = raw_s1 ^ active_low_q;
	assign hist_d  = {hist_q[HISTORY_BITS-2:0], pressed};
	assign tick_d  = tick_q + TICK_W'(1);

	bhd_match u_match (
		.hist  (hist_d),
		.pat   (pat_q),
		.flags (flags)
	);

	// elapsed times, wrapping
	assign el_press   = tick_d - pstamp_q;
	assign el_release = tick_d - rstamp_q;
	assign long_due   = el_press >= TICK_W'(lthr_q);
	assign in_window  = el_release < TICK_W'(dwin_q);

	// click machine
	always_comb begin
		phase_d  = phase_q;
		pstamp_d = pstamp_q;
		rstamp_d = rstamp_q;
		long_d   = long_q;
		clicks_d = clicks_q;
		res_d    = '0;
		if (feat_q != '0) begin
			unique case (phase_q)
				PH_IDLE: begin
					if (flags.press_match) begin
						pstamp_d = tick_d;
						clicks_d = 1'b1;
						phase_d  = PH_PRESS;
					end
				end
				PH_PRESS: begin
					if (feat_q[FEAT_LONG] && long_due && !long_q) begin
						long_d                 = 1'b1;
						phase_d                = PH_LONG;
						res_d.long_start_pulse = 1'b1;
					end else if (flags.release_match) begin
						rstamp_d = tick_d;
						if (long_q || !feat_q[FEAT_DOUBLE]) begin
							phase_d  = PH_IDLE;
							clicks_d = 1'b0;
							long_d   = 1'b0;
						end else begin
							phase_d = PH_RELEASE;
						end
					end
				end
				PH_RELEASE: begin
					if (flags.press_match && in_window) begin
						phase_d            = PH_IDLE;
						clicks_d           = 1'b0;
						long_d             = 1'b0;
						res_d.double_pulse = 1'b1;
					end else if (!in_window) begin
						phase_d            = PH_IDLE;
						clicks_d           = 1'b0;
						long_d             = 1'b0;
						res_d.single_pulse = 1'b1;
					end
				end
				PH_LONG: begin
					if (flags.release_match) begin
						phase_d              = PH_IDLE;
						clicks_d             = 1'b0;
						long_d               = 1'b0;
						res_d.long_end_pulse = 1'b1;
					end
				end
				default: begin
					phase_d = PH_IDLE;
				end
			endcase
		end
		res_d.press_pulse   = flags.press_match & ~pseen_q;
		res_d.release_pulse = flags.release_match & ~rseen_q;
		res_d.held_steady   = flags.held;
		res_d.idle_steady   = flags.idle;
		res_d.long_active   = long_d;
		res_d.click_count   = clicks_d;
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_low_q          <= RST_ACTIVE_LOW;
			feat_q                <= RST_FEATURE_ENABLE;
			dwin_q                <= RST_DOUBLE_WINDOW;
			lthr_q                <= RST_LONG_THRESHOLD;
			pat_q.press_mask      <= RST_PRESS_MASK;
			pat_q.press_pattern   <= RST_PRESS_PATTERN;
			pat_q.release_mask    <= RST_RELEASE_MASK;
			pat_q.release_pattern <= RST_RELEASE_PATTERN;
		end else if (cfg_we) begin
			unique case (cfg_sel)
				REG_ACTIVE_LOW:      active_low_q          <= cfg_data[0];
				REG_FEATURE_ENABLE:  feat_q                <= cfg_data[FEAT_W-1:0];
				REG_DOUBLE_WINDOW:   dwin_q                <= cfg_data;
				REG_LONG_THRESHOLD:  lthr_q                <= cfg_data;
				REG_PRESS_MASK:      pat_q.press_mask      <= cfg_data;
				REG_PRESS_PATTERN:   pat_q.press_pattern   <= cfg_data;
				REG_RELEASE_MASK:    pat_q.release_mask    <= cfg_data;
				REG_RELEASE_PATTERN: pat_q.release_pattern <= cfg_data;
				default: ;
			endcase
		end
	end

	// detector state, with feature disable clearing its flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q   <= '0;
			phase_q  <= PH_IDLE;
			tick_q   <= '0;
			pstamp_q <= '0;
			rstamp_q <= '0;
			long_q   <= 1'b0;
			clicks_q <= 1'b0;
			pseen_q  <= 1'b0;
			rseen_q  <= 1'b0;
		end else begin
			if (adv) begin
				hist_q   <= hist_d;
				phase_q  <= phase_d;
				tick_q   <= tick_d;
				pstamp_q <= pstamp_d;
				rstamp_q <= rstamp_d;
				long_q   <= long_d;
				clicks_q <= clicks_d;
				pseen_q  <= flags.press_match;
				rseen_q  <= flags.release_match;
			end
			if (cfg_we && cfg_sel == REG_FEATURE_ENABLE) begin
				if (!cfg_data[FEAT_DOUBLE]) begin
					clicks_q <= 1'b0;
				end
				if (!cfg_data[FEAT_LONG]) begin
					long_q <= 1'b0;
				end
			end
		end
	end

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			raw_s1 <= raw_level;
		end
		if (adv) begin
			res_q <= res_d;
		end
	end

	assign out_valid        = out_valid_q;
	assign press_pulse      = res_q.press_pulse;
	assign release_pulse    = res_q.release_pulse;
	assign held_steady      = res_q.held_steady;
	assign idle_steady      = res_q.idle_steady;
	assign single_pulse     = res_q.single_pulse;
	assign double_pulse     = res_q.double_pulse;
	assign long_start_pulse = res_q.long_start_pulse;
	assign long_end_pulse   = res_q.long_end_pulse;
	assign long_active      = res_q.long_active;
	assign click_count      = res_q.click_count;

endmodule

@@ rtl/bhd_checker.sv @@
// ----------------------------------------------------------------------------
// bhd_checker
// Port-level checks on the result channel of the debouncer core.
// ----------------------------------------------------------------------------
module bhd_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic                          press_pulse,
	input logic                          held_steady,
	input logic                          idle_steady,
	input logic                          single_pulse,
	input logic                          double_pulse,
	input logic                          long_start_pulse,
	input logic                          long_end_pulse,
	input logic                          long_active,
	input logic                          click_count
);

	// a stalled result keeps its valid and its flags
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(long_active)
		&& $stable(click_count) && $stable(press_pulse) && $stable(single_pulse))
		else $error("result changed while stalled");

	// a long press start leaves the long level set
	a_long_start: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && long_start_pulse |-> long_active)
		else $error("long start without long level");

	// a long press end clears the long level
	a_long_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && long_end_pulse |-> !long_active && !click_count)
		else $error("long end with long level still set");

	// single and double reports return the machine to idle
	a_click_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (single_pulse || double_pulse) |->
		!click_count && !long_active && !(single_pulse && double_pulse))
		else $error("click report without return to idle");

	// the history cannot be all pressed and all released
	a_steady_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(held_steady && idle_steady))
		else $error("held and idle status together");

endmodule

bind button_history_debouncer_core bhd_checker u_bhd_checker (.*);

@@ tb/button_history_debouncer_core_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// button_history_debouncer_core_tb
// Self-checking bench for the button debouncer core. Sample requests are
// driven through a directed table and then through random press/release
// gestures under several register settings. A cycle-free model of the
// history, the matches and the click machine predicts every result, and each
// result is compared field by field as it leaves the block.
// ----------------------------------------------------------------------------
module button_history_debouncer_core_tb;
	import bhd_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int PHASE_TICKS    = 100;
	localparam int RANDOM_PHASES  = 9;
	localparam int MAX_REPORTS    = 10;
	localparam int DRAIN_CYCLES   = 4;

	typedef struct packed {
		logic press_pulse;
		logic release_pulse;
		logic held_steady;
		logic idle_steady;
		logic single_pulse;
		logic double_pulse;
		logic long_start_pulse;
		logic long_end_pulse;
		logic long_active;
		logic click_count;
	} tick_result_t;

	// history all released, nothing else set
	localparam tick_result_t ONLY_IDLE = 10'b0001000000;

	typedef enum logic {ROW_TICK, ROW_WRITE} row_kind_t;

	typedef struct {
		row_kind_t        kind;
		cfg_reg_t         sel;
		logic [CFG_W-1:0] value;
		logic             fixed_en;
		tick_result_t     fixed;
	} stim_row_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	logic                 raw_level;
	logic                 out_valid;
	logic                 out_ready;
	logic                 press_pulse;
	logic                 release_pulse;
	logic                 held_steady;
	logic                 idle_steady;
	logic                 single_pulse;
	logic                 double_pulse;
	logic                 long_start_pulse;
	logic                 long_end_pulse;
	logic                 long_active;
	logic                 click_count;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	// predicted block state
	logic [HISTORY_BITS-1:0] hist;
	phase_t                  ph;
	logic [TICK_W-1:0]       tick_now;
	logic [TICK_W-1:0]       press_at;
	logic [TICK_W-1:0]       release_at;
	logic                    long_on;
	logic                    clicks_now;
	logic                    press_was;
	logic                    release_was;

	// predicted register contents
	logic              act_low;
	logic [FEAT_W-1:0] feat;
	logic [CFG_W-1:0]  dbl_win;
	logic [CFG_W-1:0]  long_thr;
	logic [CFG_W-1:0]  p_mask;
	logic [CFG_W-1:0]  p_pat;
	logic [CFG_W-1:0]  r_mask;
	logic [CFG_W-1:0]  r_pat;

	tick_result_t pending_results[$];
	stim_row_t    directed_rows[$];
	logic         row_fixed_en;
	tick_result_t row_fixed;
	int           mismatches;
	int           results_seen;
	int           quiet_cycles;
	int           phase_items;
	int           send_idle_pct;
	int           recv_idle_pct;

	string field_names [10] = '{"click_count", "long_active", "long_end_pulse",
		"long_start_pulse", "double_pulse", "single_pulse", "idle_steady",
		"held_steady", "release_pulse", "press_pulse"};

	button_history_debouncer_core dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.raw_level        (raw_level),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.press_pulse      (press_pulse),
		.release_pulse    (release_pulse),
		.held_steady      (held_steady),
		.idle_steady      (idle_steady),
		.single_pulse     (single_pulse),
		.double_pulse     (double_pulse),
		.long_start_pulse (long_start_pulse),
		.long_end_pulse   (long_end_pulse),
		.long_active      (long_active),
		.click_count      (click_count),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data)
	);

	// 100 MHz clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// ------------------------------------------------------------------
	// prediction
	// ------------------------------------------------------------------

	function automatic void return_to_idle();
		ph         = PH_IDLE;
		clicks_now = 1'b0;
		long_on    = 1'b0;
	endfunction

	function automatic void apply_reg_write(input logic [CFG_IDX_W-1:0] sel,
			input logic [CFG_W-1:0] value);
		case (sel)
			REG_ACTIVE_LOW: act_low = value[0];
			REG_FEATURE_ENABLE: begin
				feat = value[FEAT_W-1:0];
				// turning a feature off drops its part of the machine state
				if (!feat[FEAT_DOUBLE])
					clicks_now = 1'b0;
				if (!feat[FEAT_LONG])
					long_on = 1'b0;
			end
			REG_DOUBLE_WINDOW:   dbl_win  = value;
			REG_LONG_THRESHOLD:  long_thr = value;
			REG_PRESS_MASK:      p_mask   = value;
			REG_PRESS_PATTERN:   p_pat    = value;
			REG_RELEASE_MASK:    r_mask   = value;
			REG_RELEASE_PATTERN: r_pat    = value;
			default: ;
		endcase
	endfunction

	function automatic tick_result_t debounce_tick(input logic lvl);
		tick_result_t      r;
		logic              pm;
		logic              rm;
		logic [TICK_W-1:0] elapsed;
		r        = '0;
		tick_now = tick_now + 1'b1;
		hist     = {hist[HISTORY_BITS-2:0], lvl ^ act_low};
		pm       = (hist[MATCH_W-1:0] & p_mask) == p_pat;
		rm       = (hist[MATCH_W-1:0] & r_mask) == r_pat;

		// pulses only on the first matching tick
		r.press_pulse   = pm & ~press_was;
		r.release_pulse = rm & ~release_was;
		press_was       = pm;
		release_was     = rm;

		// click machine, frozen while no feature is on
		if (feat != '0) begin
			case (ph)
				PH_IDLE: begin
					if (pm) begin
						press_at   = tick_now;
						clicks_now = 1'b1;
						ph         = PH_PRESS;
					end
				end
				PH_PRESS: begin
					elapsed = tick_now - press_at;
					if (feat[FEAT_LONG] && elapsed >= {16'd0, long_thr} && !long_on) begin
						long_on            = 1'b1;
						ph                 = PH_LONG;
						r.long_start_pulse = 1'b1;
					end else if (rm) begin
						release_at = tick_now;
						if (long_on || !feat[FEAT_DOUBLE])
							return_to_idle();
						else
							ph = PH_RELEASE;
					end
				end
				PH_RELEASE: begin
					elapsed = tick_now - release_at;
					if (pm && elapsed < {16'd0, dbl_win}) begin
						return_to_idle();
						r.double_pulse = 1'b1;
					end else if (elapsed >= {16'd0, dbl_win}) begin
						r.single_pulse = 1'b1;
						return_to_idle();
					end
				end
				default: begin
					// long phase ends on release even with the long feature off
					if (rm) begin
						long_on          = 1'b0;
						r.long_end_pulse = 1'b1;
						return_to_idle();
					end
				end
			endcase
		end

		r.held_steady = &hist;
		r.idle_steady = (hist == '0);
		r.long_active = long_on;
		r.click_count = clicks_now;
		return r;
	endfunction

	// ------------------------------------------------------------------
	// scoreboard and watchdog
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		tick_result_t seen;
		tick_result_t want;
		tick_result_t predicted;
		if (arst_n) begin
			// compare before pushing so an early result is never matched
			if (out_valid && out_ready) begin
				seen = {press_pulse, release_pulse, held_steady, idle_steady, single_pulse,
					double_pulse, long_start_pulse, long_end_pulse, long_active, click_count};
				results_seen++;
				if (pending_results.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("result %0d: %b arrived with no request pending",
							results_seen, seen);
				end else begin
					want = pending_results.pop_front();
					for (int f = $bits(tick_result_t) - 1; f >= 0; f--) begin
						if (seen[f] !== want[f]) begin
							mismatches++;
							if (mismatches <= MAX_REPORTS)
								$display("result %0d: %s expected %0b got %0b",
									results_seen, field_names[f], want[f], seen[f]);
						end
					end
				end
			end

			if (cfg_we)
				apply_reg_write(cfg_index, cfg_data);

			if (in_valid && in_ready) begin
				predicted = debounce_tick(raw_level);
				pending_results.push_back(row_fixed_en ? row_fixed : predicted);
			end

			// no handshake on either side for too long
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= WATCHDOG_LIMIT) begin
					$display("Regression FAIL");
					$finish;
				end
			end
		end
	end

	// result side back-pressure
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	// ------------------------------------------------------------------
	// drivers
	// ------------------------------------------------------------------

	// one sample request; entered and left on a falling edge
	task automatic send_tick(input logic lvl, input logic fixed_en, input tick_result_t fixed);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid     <= 1'b1;
		raw_level    <= lvl;
		row_fixed_en  = fixed_en;
		row_fixed     = fixed;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_pressed(input logic pressed);
		send_tick(pressed ^ act_low, 1'b0, '0);
		phase_items++;
	endtask

	task automatic write_reg(input cfg_reg_t sel, input logic [CFG_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= sel;
		cfg_data  <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// stop sending and let every request in flight come out
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic add_tick(input logic lvl, input logic fixed_en, input tick_result_t fixed);
		directed_rows.push_back('{ROW_TICK, REG_ACTIVE_LOW, {15'd0, lvl}, fixed_en, fixed});
	endtask

	task automatic add_write(input cfg_reg_t sel, input logic [CFG_W-1:0] value);
		directed_rows.push_back('{ROW_WRITE, sel, value, 1'b0, tick_result_t'(0)});
	endtask

	// settings for one random stretch, extremes on fixed stretches
	task automatic program_phase(input int p);
		logic [CFG_W-1:0] pm;
		logic [CFG_W-1:0] pp;
		logic [CFG_W-1:0] rm;
		logic [CFG_W-1:0] rp;
		logic [CFG_W-1:0] win;
		logic [CFG_W-1:0] thr;
		logic [CFG_W-1:0] fe_word;
		int               n;
		int               m;
		n = $urandom_range(1, 6);
		m = $urandom_range(1, 6);
		case (p % 3)
			0: begin
				pm = RST_PRESS_MASK;
				pp = RST_PRESS_PATTERN;
				rm = RST_RELEASE_MASK;
				rp = RST_RELEASE_PATTERN;
			end
			1: begin
				// n pressed after m released, and the mirror for release
				pm = CFG_W'((1 << (n + m)) - 1);
				pp = CFG_W'((1 << n) - 1);
				rm = pm;
				rp = CFG_W'(((1 << m) - 1) << n);
			end
			default: begin
				pm = CFG_W'($urandom);
				pp = CFG_W'($urandom) & pm;
				rm = CFG_W'($urandom);
				rp = CFG_W'($urandom) & rm;
			end
		endcase
		if (p == 7) begin
			// empty masks: both patterns match on every tick
			pm = '0;
			pp = '0;
			rm = '0;
			rp = '0;
		end
		if (p == 8) begin
			pm = '1;
			pp = '1;
			rm = '1;
			rp = '0;
		end
		win = (p == 2) ? 16'hFFFF : (p == 5) ? 16'h0000 : CFG_W'($urandom_range(1, 40));
		thr = (p == 3) ? 16'hFFFF : (p == 6) ? 16'h0000 : CFG_W'($urandom_range(1, 50));
		fe_word = CFG_W'($urandom);
		fe_word[FEAT_W-1:0] = (p == 4) ? 2'd0 : FEAT_W'(1 + p % 3);

		write_reg(REG_ACTIVE_LOW, CFG_W'($urandom));
		write_reg(REG_FEATURE_ENABLE, fe_word);
		write_reg(REG_DOUBLE_WINDOW, win);
		write_reg(REG_LONG_THRESHOLD, thr);
		write_reg(REG_PRESS_MASK, pm);
		write_reg(REG_PRESS_PATTERN, pp);
		write_reg(REG_RELEASE_MASK, rm);
		write_reg(REG_RELEASE_PATTERN, rp);
	endtask

	// a bounced press and release, or a burst of noise
	task automatic drive_gesture();
		int kind;
		int hold;
		int gap;
		int cap_thr;
		int cap_win;
		kind    = $urandom_range(0, 9);
		cap_thr = (long_thr > 60) ? 60 : int'(long_thr);
		cap_win = (dbl_win > 40) ? 40 : int'(dbl_win);
		if (kind == 0) begin
			repeat ($urandom_range(1, 8)) send_pressed(1'($urandom_range(0, 1)));
		end else begin
			repeat ($urandom_range(0, 3)) send_pressed(1'($urandom_range(0, 1)));
			hold = (kind <= 2) ? cap_thr + $urandom_range(0, 4) : $urandom_range(1, 20);
			repeat (hold) send_pressed(1'b1);
			repeat ($urandom_range(0, 3)) send_pressed(1'($urandom_range(0, 1)));
			// odd kinds try to come back inside the double window
			gap = (kind % 2) ? $urandom_range(1, cap_win + 4) : cap_win + $urandom_range(1, 24);
			repeat (gap) send_pressed(1'b0);
		end
	endtask

	// ------------------------------------------------------------------
	// stimulus
	// ------------------------------------------------------------------
	initial begin
		in_valid      = 1'b0;
		raw_level     = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = REG_ACTIVE_LOW;
		cfg_data      = '0;
		row_fixed_en  = 1'b0;
		row_fixed     = '0;
		mismatches    = 0;
		results_seen  = 0;
		quiet_cycles  = 0;
		phase_items   = 0;
		send_idle_pct = 19;
		recv_idle_pct = 87;

		// model state and registers after reset
		hist        = '0;
		ph          = PH_IDLE;
		tick_now    = '0;
		press_at    = '0;
		release_at  = '0;
		long_on     = 1'b0;
		clicks_now  = 1'b0;
		press_was   = 1'b0;
		release_was = 1'b0;
		act_low     = RST_ACTIVE_LOW;
		feat        = RST_FEATURE_ENABLE;
		dbl_win     = RST_DOUBLE_WINDOW;
		long_thr    = RST_LONG_THRESHOLD;
		p_mask      = RST_PRESS_MASK;
		p_pat       = RST_PRESS_PATTERN;
		r_mask      = RST_RELEASE_MASK;
		r_pat       = RST_RELEASE_PATTERN;

		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// high pin under active low reads released
		add_tick(1'b1, 1'b1, ONLY_IDLE);
		add_tick(1'b1, 1'b1, ONLY_IDLE);
		add_tick(1'b0, 1'b0, '0);
		// two-tick patterns, machine still off
		add_write(REG_ACTIVE_LOW, 16'h0000);
		add_write(REG_PRESS_MASK, 16'h0003);
		add_write(REG_PRESS_PATTERN, 16'h0003);
		add_write(REG_RELEASE_MASK, 16'h0003);
		add_write(REG_RELEASE_PATTERN, 16'h0000);
		add_tick(1'b1, 1'b0, '0);
		add_tick(1'b1, 1'b0, '0);
		add_tick(1'b0, 1'b0, '0);
		add_tick(1'b0, 1'b0, '0);
		// double press, then the held level starts a new press and goes long
		add_write(REG_FEATURE_ENABLE, 16'h0003);
		add_write(REG_DOUBLE_WINDOW, 16'd4);
		add_write(REG_LONG_THRESHOLD, 16'd3);
		repeat (2) add_tick(1'b1, 1'b0, '0);
		repeat (2) add_tick(1'b0, 1'b0, '0);
		repeat (6) add_tick(1'b1, 1'b0, '0);
		// long feature dropped while long, release still ends it
		add_write(REG_FEATURE_ENABLE, 16'h0001);
		repeat (2) add_tick(1'b0, 1'b0, '0);
		// zero window gives a single at once
		add_write(REG_DOUBLE_WINDOW, 16'h0000);
		repeat (2) add_tick(1'b1, 1'b0, '0);
		repeat (3) add_tick(1'b0, 1'b0, '0);
		// zero threshold goes long on the tick after the press
		add_write(REG_LONG_THRESHOLD, 16'h0000);
		add_write(REG_FEATURE_ENABLE, 16'h0002);
		repeat (3) add_tick(1'b1, 1'b0, '0);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_WRITE) begin
				wait_drained();
				write_reg(directed_rows[i].sel, directed_rows[i].value);
			end else begin
				send_tick(directed_rows[i].value[0], directed_rows[i].fixed_en,
					directed_rows[i].fixed);
			end
		end

		// random gestures, idle pattern swapped per third
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			if (p == RANDOM_PHASES / 3) begin
				send_idle_pct = 87;
				recv_idle_pct = 19;
			end else if (p == 2 * RANDOM_PHASES / 3) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			wait_drained();
			program_phase(p);
			phase_items = 0;
			while (phase_items < PHASE_TICKS)
				drive_gesture();
		end

		wait_drained();
		if (mismatches == 0 && pending_results.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

@@ files.f @@
rtl/bhd_pkg.sv
rtl/bhd_match.sv
rtl/button_history_debouncer_core.sv
rtl/bhd_checker.sv
tb/button_history_debouncer_core_tb.sv
